// ===== sv/audio_level_led_bar_driver_top_defines.svh =====
// ----------------------------------------------------------------------------
// audio_level_led_bar_driver_top_defines.svh
// Assertion macros for the LED bar driver. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LEVEL_LED_BAR_DRIVER_TOP_DEFINES_SVH
`define AUDIO_LEVEL_LED_BAR_DRIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ALBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALBD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ALBD_ASSERT_IMP(label, ante, cons, msg)
`define ALBD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/albd_pkg.sv =====
// ----------------------------------------------------------------------------
// albd_pkg
// Types, constants and small tables shared by the LED bar driver modules.
// ----------------------------------------------------------------------------
package albd_pkg;

	// register indexes of the configuration port
	localparam logic [3:0] REG_LED_COUNT    = 4'd0;
	localparam logic [3:0] REG_RGB_ENABLE   = 4'd1;
	localparam logic [3:0] REG_ACTIVE_LEVEL = 4'd2;
	localparam logic [3:0] REG_DUTY_FULL    = 4'd3;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// number of duty fields on the result word
	localparam int OUT_LEDS = 4;

	// level and peak constants
	localparam logic [15:0] QUIET_LIMIT = 16'd16;
	localparam logic [15:0] PEAK_RESET  = 16'h0100;

	// floor(x / 3) for 16-bit x = (x * 43691) >> 17
	localparam logic [16:0] DIV3_MUL = 17'd43691;
	localparam int          DIV3_SH  = 17;

	// serial divider geometry
	localparam int DVD_W   = 24;
	localparam int DVS_W   = 16;
	localparam int SHORT_W = 16;
	localparam int DCNT_W  = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SELECT,
		ST_OVER,
		ST_QDIV,
		ST_QWAIT,
		ST_BLANK,
		ST_PRST,
		ST_SIZE,
		ST_SWAIT,
		ST_POS,
		ST_PWAIT,
		ST_MULF,
		ST_FRAC,
		ST_FWAIT,
		ST_DONE
	} state_t;

	// what the result word carries on the duty fields
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ZERO,
		KIND_MARQ,
		KIND_BAR
	} kind_t;

	// divider operation in flight
	typedef enum logic [1:0] {
		OP_Q,
		OP_SIZE,
		OP_POS,
		OP_PART
	} op_t;

	typedef struct packed {
		logic  capture;
		logic  mode_step;
		logic  tick_inc;
		logic  kind_set;
		kind_t kind;
		logic  peak_chk;
		logic  quiet;
		logic  div3;
		logic  q_sat;
		logic  div_start;
		op_t   op;
		logic  blank;
		logic  peak_rst;
		logic  bar_zero;
		logic  mulf;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic loud;
		logic bar_on;
		logic bar_en;
		logic over;
		logic div3_zero;
		logic size_zero;
		logic div_busy;
		logic div_done;
	} sts_t;

	// marquee pattern, columns 0 and 1; higher LEDs stay dark
	function automatic logic marquee_on(input logic [2:0] step, input logic col);
		logic [1:0] row;
		case (step)
			3'd0: row = 2'b10;
			3'd1: row = 2'b01;
			3'd2: row = 2'b00;
			3'd3: row = 2'b10;
			3'd4: row = 2'b11;
			3'd5: row = 2'b10;
			default: row = 2'b00;
		endcase
		return row[col];
	endfunction

	// colour cycle, returns {red, green, blue}
	function automatic logic [2:0] colour_row(input logic [2:0] row);
		logic [2:0] rgb;
		case (row)
			3'd0: rgb = 3'b100;
			3'd1: rgb = 3'b010;
			3'd2: rgb = 3'b001;
			3'd3: rgb = 3'b110;
			3'd4: rgb = 3'b101;
			3'd5: rgb = 3'b011;
			default: rgb = 3'b000;
		endcase
		return rgb;
	endfunction

endpackage

// ===== sv/audio_level_led_bar_driver_top.sv =====
// ----------------------------------------------------------------------------
// audio_level_led_bar_driver_top
// VU-meter LED bar driver with auto-gain peak tracking, quiet marquee and
// RGB colour cycle, one word per frame tick or mode-change event.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  ------------------------------------------
//   in       in_valid / in_ready   mode, rms_level
//   out      out_valid / out_ready duty_led0..3, duty_write_mask, rgb_*
//   cfg      cfg_we                cfg_index, cfg_data (no wait, no read)
//
// One word is in work at a time. From accept to a loaded result a loud tick
// runs up to four divider passes of 16, 16, 16 and 24 steps, each with a
// one-cycle done pulse. Input is taken again in the cycle after the load.
// The finished word waits in an output register, so a stalled output only
// holds the controller in its last state. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "audio_level_led_bar_driver_top_defines.svh"

module audio_level_led_bar_driver_top #(
	parameter int LED_SLOTS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [15:0]                      rms_level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       duty_led0,
	output logic [7:0]                       duty_led1,
	output logic [7:0]                       duty_led2,
	output logic [7:0]                       duty_led3,
	output logic [3:0]                       duty_write_mask,
	output logic                             rgb_red,
	output logic                             rgb_green,
	output logic                             rgb_blue,
	output logic                             rgb_write,
	input  logic                             cfg_we,
	input  logic [albd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [albd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import albd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	albd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	albd_dp #(
		.LED_SLOTS (LED_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.rms_level       (rms_level),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.duty_led0       (duty_led0),
		.duty_led1       (duty_led1),
		.duty_led2       (duty_led2),
		.duty_led3       (duty_led3),
		.duty_write_mask (duty_write_mask),
		.rgb_red         (rgb_red),
		.rgb_green       (rgb_green),
		.rgb_blue        (rgb_blue),
		.rgb_write       (rgb_write)
	);

	// checks
	`ALBD_ASSERT_NXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken while busy")
	`ALBD_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "result overwritten")
	`ALBD_ASSERT_IMP(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")

endmodule

// ===== sv/albd_div.sv =====
// ----------------------------------------------------------------------------
// albd_div
// Restoring divider, one quotient bit per cycle. Short operations run 16
// steps on the low 16 dividend bits, long ones run all 24.
// ----------------------------------------------------------------------------
module albd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        long_op,
	input  logic [albd_pkg::DVD_W-1:0]  dividend,
	input  logic [albd_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic                        done,
	output logic [albd_pkg::DVD_W-1:0]  quo,
	output logic [albd_pkg::DVS_W-1:0]  rem
);
	import albd_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]    acc_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVS_W:0]      trial;
	logic                ge;

	// trial subtract of the next partial remainder
	assign trial = {acc_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	// control: busy flag, step count, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= long_op ? DCNT_W'(DVD_W) : DCNT_W'(SHORT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in dividend bits, shift out quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= '0;
			dvs_q <= divisor;
			dvd_q <= long_op ? dividend
				: {dividend[SHORT_W-1:0], {(DVD_W-SHORT_W){1'b0}}};
		end else if (busy_q) begin
			acc_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = acc_q;

endmodule

// ===== sv/albd_dp.sv =====
// ----------------------------------------------------------------------------
// albd_dp
// Datapath: configuration registers, tick counter with its residues, peak
// tracking, the serial divider and the result word register.
// ----------------------------------------------------------------------------
module albd_dp #(
	parameter int LED_SLOTS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  albd_pkg::cmd_t                   cmd,
	output albd_pkg::sts_t                   sts,
	input  logic                             mode,
	input  logic [15:0]                      rms_level,
	input  logic                             cfg_we,
	input  logic [albd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [albd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [7:0]                       duty_led0,
	output logic [7:0]                       duty_led1,
	output logic [7:0]                       duty_led2,
	output logic [7:0]                       duty_led3,
	output logic [3:0]                       duty_write_mask,
	output logic                             rgb_red,
	output logic                             rgb_green,
	output logic                             rgb_blue,
	output logic                             rgb_write
);
	import albd_pkg::*;

	localparam int NW = $clog2(LED_SLOTS + 1);

	// configuration
	logic [7:0]  led_count_q;
	logic        rgb_enable_q;
	logic        active_level_q;
	logic [7:0]  duty_full_q;

	// item and block state
	logic        mode_q;
	logic [15:0] level_q;
	logic [31:0] tick_q;
	logic [1:0]  r3_q;
	logic [2:0]  r5_q;
	logic [4:0]  r20_q;
	logic [4:0]  r28_q;
	logic [6:0]  r96_q;
	logic [15:0] peak_q;
	logic [1:0]  fm_q;

	// working registers
	logic [15:0] div3_q;
	logic [1:0]  q_q;
	logic [15:0] size_q;
	logic [7:0]  pos_q;
	logic [15:0] frac_q;
	logic [23:0] prod_q;
	logic [7:0]  part_q;
	kind_t       kind_q;
	op_t         op_q;

	// result word
	logic [7:0]  duty_q [OUT_LEDS];
	logic [3:0]  mask_q;
	logic [2:0]  rgb_q;
	logic        rgb_wr_q;

	logic [NW-1:0]     n_w;
	logic [31:0]       tick_nx;
	logic              wrap;
	logic [32:0]       div3_prod;
	logic              blank_hit;
	logic              div_busy;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic [DVD_W-1:0]  dvd_sel;
	logic [DVS_W-1:0]  dvs_sel;
	logic [7:0]        duty_w [OUT_LEDS];
	logic [3:0]        mask_w;
	logic [2:0]        rgb_w;
	logic              rgb_wr_w;
	logic [3:0]        n4;
	logic [3:0]        slot4 [OUT_LEDS];

	// bar LED count in use
	assign n_w = (led_count_q > 8'(LED_SLOTS)) ? NW'(LED_SLOTS) : NW'(led_count_q);
	assign n4  = 4'(n_w);

	// status to controller
	assign sts.mode      = mode_q;
	assign sts.loud      = level_q > QUIET_LIMIT;
	assign sts.bar_on    = led_count_q > 8'd1;
	assign sts.bar_en    = fm_q[1];
	assign sts.over      = level_q > peak_q;
	assign sts.div3_zero = div3_q == '0;
	assign sts.size_zero = size_q == '0;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q    <= 8'd2;
			rgb_enable_q   <= 1'b1;
			active_level_q <= 1'b1;
			duty_full_q    <= 8'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LED_COUNT:    led_count_q    <= cfg_data;
				REG_RGB_ENABLE:   rgb_enable_q   <= cfg_data[0];
				REG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				REG_DUTY_FULL:    duty_full_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick counter and residues mod 3, 5, 20, 28, 96; a wrap to zero restarts them
	assign tick_nx = tick_q + 32'd1;
	assign wrap    = tick_nx == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			r3_q   <= '0;
			r5_q   <= '0;
			r20_q  <= '0;
			r28_q  <= '0;
			r96_q  <= '0;
		end else if (cmd.tick_inc) begin
			tick_q <= tick_nx;
			r3_q   <= (wrap || r3_q == 2'd2)   ? '0 : r3_q + 2'd1;
			r5_q   <= (wrap || r5_q == 3'd4)   ? '0 : r5_q + 3'd1;
			r20_q  <= (wrap || r20_q == 5'd19) ? '0 : r20_q + 5'd1;
			r28_q  <= (wrap || r28_q == 5'd27) ? '0 : r28_q + 5'd1;
			r96_q  <= (wrap || r96_q == 7'd95) ? '0 : r96_q + 7'd1;
		end
	end

	// function mode: 3 -> 2 -> 0 -> 3, unused code goes to 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_q <= 2'd3;
		end else if (cmd.mode_step) begin
			case (fm_q)
				2'd3: fm_q <= 2'd2;
				2'd2: fm_q <= 2'd0;
				default: fm_q <= 2'd3;
			endcase
		end
	end

	// blank check: tick mod (5 - q) == 0
	always_comb begin
		case (q_q)
			2'd0: blank_hit = r5_q == '0;
			2'd1: blank_hit = tick_q[1:0] == 2'd0;
			2'd2: blank_hit = r3_q == '0;
			default: blank_hit = tick_q[0] == 1'b0;
		endcase
	end

	// peak tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= PEAK_RESET;
		end else begin
			if (cmd.quiet) begin
				peak_q <= PEAK_RESET;
			end else if (cmd.peak_chk && {1'b0, level_q} > {peak_q, 1'b0}) begin
				peak_q <= level_q;
			end else if (cmd.peak_rst && r20_q == '0) begin
				peak_q <= PEAK_RESET;
			end
		end
	end

	// divider operands
	always_comb begin
		case (cmd.op)
			OP_Q: begin
				dvd_sel = DVD_W'(level_q - peak_q);
				dvs_sel = div3_q;
			end
			OP_SIZE: begin
				dvd_sel = DVD_W'(peak_q);
				dvs_sel = DVS_W'(n_w) + DVS_W'(1);
			end
			OP_POS: begin
				dvd_sel = DVD_W'(level_q);
				dvs_sel = size_q;
			end
			default: begin
				dvd_sel = prod_q;
				dvs_sel = size_q;
			end
		endcase
	end

	albd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.long_op  (cmd.op == OP_PART),
		.dividend (dvd_sel),
		.divisor  (dvs_sel),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign div3_prod = peak_q * DIV3_MUL;

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			level_q <= rms_level;
		end else if (cmd.blank && blank_hit) begin
			level_q <= '0;
		end
		if (cmd.div3) begin
			div3_q <= div3_prod[DIV3_SH +: 16];
		end
		if (cmd.q_sat) begin
			q_q <= 2'd3;
		end
		if (cmd.div_start) begin
			op_q <= cmd.op;
		end
		if (cmd.mulf) begin
			prod_q <= 24'(frac_q * duty_full_q);
		end
		if (cmd.bar_zero) begin
			pos_q  <= '0;
			part_q <= '0;
		end
		if (div_done) begin
			case (op_q)
				OP_Q: q_q <= (div_quo > DVD_W'(3)) ? 2'd3 : div_quo[1:0];
				OP_SIZE: size_q <= div_quo[15:0];
				OP_POS: begin
					pos_q  <= (div_quo[DVD_W-1:8] != '0) ? 8'd255 : div_quo[7:0];
					frac_q <= div_rem;
				end
				default: part_q <= div_quo[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cmd.kind_set) begin
			kind_q <= cmd.kind;
		end
	end

	// result word assembly
	always_comb begin
		mask_w = '0;
		for (int k = 0; k < OUT_LEDS; k++) begin
			slot4[k]  = n4 - 4'd1 - 4'(k);
			duty_w[k] = '0;
			if (4'(k) < n4) begin
				case (kind_q)
					KIND_ZERO: mask_w[k] = 1'b1;
					KIND_MARQ: begin
						if (tick_q[1:0] == 2'd0) begin
							mask_w[k] = 1'b1;
							if (k < 2 && marquee_on(r28_q[4:2], 1'(k))) begin
								duty_w[k] = duty_full_q;
							end
						end
					end
					KIND_BAR: begin
						mask_w[k] = 1'b1;
						if (8'(slot4[k]) < pos_q) begin
							duty_w[k] = duty_full_q;
						end else if (8'(slot4[k]) == pos_q) begin
							duty_w[k] = part_q;
						end
					end
					default: ;
				endcase
			end
		end
		rgb_wr_w = !mode_q && rgb_enable_q && tick_q[3:0] == 4'd0;
		rgb_w    = '0;
		if (rgb_wr_w) begin
			rgb_w = fm_q[0] ? colour_row(r96_q[6:4]) : {3{~active_level_q}};
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			duty_q   <= duty_w;
			mask_q   <= mask_w;
			rgb_q    <= rgb_w;
			rgb_wr_q <= rgb_wr_w;
		end
	end

	assign duty_led0       = duty_q[0];
	assign duty_led1       = duty_q[1];
	assign duty_led2       = duty_q[2];
	assign duty_led3       = duty_q[3];
	assign duty_write_mask = mask_q;
	assign rgb_red         = rgb_q[2];
	assign rgb_green       = rgb_q[1];
	assign rgb_blue        = rgb_q[0];
	assign rgb_write       = rgb_wr_q;

endmodule

// ===== sv/albd_ctrl.sv =====
// ----------------------------------------------------------------------------
// albd_ctrl
// Controller: sequences one word through the datapath and owns both
// handshakes.
// ----------------------------------------------------------------------------
module albd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output albd_pkg::cmd_t  cmd,
	input  albd_pkg::sts_t  sts
);
	import albd_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nx = ST_DISPATCH;
			ST_DISPATCH: state_nx = sts.mode ? ST_DONE : ST_SELECT;
			ST_SELECT: begin
				if (sts.bar_on && sts.bar_en && sts.loud) begin
					state_nx = ST_OVER;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_OVER:  state_nx = sts.over ? ST_QDIV : ST_PRST;
			ST_QDIV:  state_nx = sts.div3_zero ? ST_BLANK : ST_QWAIT;
			ST_QWAIT: if (sts.div_done) state_nx = ST_BLANK;
			ST_BLANK: state_nx = ST_PRST;
			ST_PRST:  state_nx = ST_SIZE;
			ST_SIZE:  state_nx = ST_SWAIT;
			ST_SWAIT: if (sts.div_done) state_nx = ST_POS;
			ST_POS:   state_nx = sts.size_zero ? ST_DONE : ST_PWAIT;
			ST_PWAIT: if (sts.div_done) state_nx = ST_MULF;
			ST_MULF:  state_nx = ST_FRAC;
			ST_FRAC:  state_nx = ST_FWAIT;
			ST_FWAIT: if (sts.div_done) state_nx = ST_DONE;
			ST_DONE:  if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.kind = KIND_NONE;
		cmd.op   = OP_Q;
		case (state_q)
			ST_IDLE: cmd.capture = in_valid;
			ST_DISPATCH: begin
				cmd.mode_step = sts.mode;
				cmd.tick_inc  = !sts.mode;
				cmd.kind_set  = 1'b1;
			end
			ST_SELECT: begin
				if (sts.bar_on) begin
					cmd.kind_set = 1'b1;
					if (!sts.bar_en) begin
						cmd.kind = KIND_ZERO;
					end else if (!sts.loud) begin
						cmd.kind  = KIND_MARQ;
						cmd.quiet = 1'b1;
					end else begin
						cmd.kind     = KIND_BAR;
						cmd.peak_chk = 1'b1;
					end
				end
			end
			ST_OVER: cmd.div3 = sts.over;
			ST_QDIV: begin
				cmd.q_sat     = sts.div3_zero;
				cmd.div_start = !sts.div3_zero;
				cmd.op        = OP_Q;
			end
			ST_BLANK: cmd.blank = 1'b1;
			ST_PRST:  cmd.peak_rst = 1'b1;
			ST_SIZE: begin
				cmd.div_start = 1'b1;
				cmd.op        = OP_SIZE;
			end
			ST_POS: begin
				cmd.bar_zero  = sts.size_zero;
				cmd.div_start = !sts.size_zero;
				cmd.op        = OP_POS;
			end
			ST_MULF: cmd.mulf = 1'b1;
			ST_FRAC: begin
				cmd.div_start = 1'b1;
				cmd.op        = OP_PART;
			end
			ST_DONE: cmd.load_out = out_free;
			default: ;
		endcase
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
